@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/cglp_pkg.sv @@
// ----------------------------------------------------------------------------
// cglp_pkg
// types and constants of the complex gaussian sample generator
// ----------------------------------------------------------------------------
`default_nettype none

package cglp_pkg;

    localparam logic [30:0] LCG_MUL    = 31'd16807;
    localparam logic [30:0] LCG_MOD    = 31'h7FFF_FFFF;
    localparam logic [30:0] XOR_MASK   = 31'd123459876;
    localparam logic [63:0] LN2_Q64    = 64'hB172_17F7_D1CF_79AB;
    localparam logic [63:0] ACCEPT_MAX = 64'h4000_0000_0000_0000;
    localparam logic [5:0]  LOG_LAST   = 6'd39;
    localparam logic [5:0]  SQRT_LAST  = 6'd35;
    localparam logic [5:0]  DIV_LAST   = 6'd32;
    localparam logic [2:0]  MUL_LAST   = 3'd4;

    typedef enum logic [2:0] {
        MUL_SQ1,
        MUL_SQ2,
        MUL_LOG,
        MUL_LN,
        MUL_COMP
    } t_mul_sel;

    typedef enum logic {
        SQRT_LN,
        SQRT_DEN
    } t_sqrt_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_LCG1,
        S_LCG2,
        S_SQ1_GO,
        S_SQ1_WAIT,
        S_SQ1_CAP,
        S_SQ2_WAIT,
        S_SQ2_CAP,
        S_TEST,
        S_NORM,
        S_MCAP,
        S_LOG_GO,
        S_LOG_WAIT,
        S_LOG_UPD,
        S_LN_GO,
        S_LN_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_SQD_GO,
        S_SQD_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CM_GO,
        S_CM_WAIT,
        S_RES,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load;
        logic      set_stuck;
        logic      lcg1;
        logic      lcg2;
        logic      mul_go;
        t_mul_sel  mul_sel;
        logic      cap_sq1;
        logic      cap_sq2;
        logic      commit;
        logic      norm_start;
        logic      norm_step;
        logic      cap_m;
        logic      log_upd;
        logic      sqrt_go;
        t_sqrt_sel sqrt_sel;
        logic      cap_r;
        logic      div_go;
        logic      comp;
        logic      res_cap;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic stuck;
        logic test_ok;
        logic norm_done;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

@@ sv/cglp_ctrl.sv @@
// ----------------------------------------------------------------------------
// cglp_ctrl
// sequencer: rejection loop, log iterations, root, divide and scale steps
// ----------------------------------------------------------------------------
`default_nettype none

module cglp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_free,
    input  wire cglp_pkg::t_status i_status,
    output cglp_pkg::t_cmd         o_cmd
);

    cglp_pkg::t_state r_fsm, n_fsm;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= cglp_pkg::S_IDLE;
            r_cnt  <= '0;
            r_comp <= 1'b0;
        end else begin
            r_fsm  <= n_fsm;
            r_cnt  <= n_cnt;
            r_comp <= n_comp;
        end
    end

    // next state
    always_comb begin
        n_fsm  = r_fsm;
        n_cnt  = r_cnt;
        n_comp = r_comp;
        unique case (r_fsm)
            cglp_pkg::S_IDLE: begin
                n_comp = 1'b0;
                if (i_in_valid) n_fsm = cglp_pkg::S_CHK;
            end
            cglp_pkg::S_CHK: begin
                n_fsm = i_status.stuck ? cglp_pkg::S_DONE : cglp_pkg::S_LCG1;
            end
            cglp_pkg::S_LCG1:     n_fsm = cglp_pkg::S_LCG2;
            cglp_pkg::S_LCG2:     n_fsm = cglp_pkg::S_SQ1_GO;
            cglp_pkg::S_SQ1_GO:   n_fsm = cglp_pkg::S_SQ1_WAIT;
            cglp_pkg::S_SQ1_WAIT: if (i_status.mul_done) n_fsm = cglp_pkg::S_SQ1_CAP;
            cglp_pkg::S_SQ1_CAP:  n_fsm = cglp_pkg::S_SQ2_WAIT;
            cglp_pkg::S_SQ2_WAIT: if (i_status.mul_done) n_fsm = cglp_pkg::S_SQ2_CAP;
            cglp_pkg::S_SQ2_CAP:  n_fsm = cglp_pkg::S_TEST;
            cglp_pkg::S_TEST: begin
                n_fsm = i_status.test_ok ? cglp_pkg::S_NORM : cglp_pkg::S_LCG1;
            end
            cglp_pkg::S_NORM:     if (i_status.norm_done) n_fsm = cglp_pkg::S_MCAP;
            cglp_pkg::S_MCAP: begin
                n_cnt = '0;
                n_fsm = cglp_pkg::S_LOG_WAIT;
            end
            cglp_pkg::S_LOG_GO:   n_fsm = cglp_pkg::S_LOG_WAIT;
            cglp_pkg::S_LOG_WAIT: if (i_status.mul_done) n_fsm = cglp_pkg::S_LOG_UPD;
            cglp_pkg::S_LOG_UPD: begin
                n_cnt = r_cnt + 6'd1;
                n_fsm = (r_cnt == cglp_pkg::LOG_LAST) ? cglp_pkg::S_LN_GO
                                                      : cglp_pkg::S_LOG_GO;
            end
            cglp_pkg::S_LN_GO:    n_fsm = cglp_pkg::S_LN_WAIT;
            cglp_pkg::S_LN_WAIT:  if (i_status.mul_done) n_fsm = cglp_pkg::S_SQR_GO;
            cglp_pkg::S_SQR_GO:   n_fsm = cglp_pkg::S_SQR_WAIT;
            cglp_pkg::S_SQR_WAIT: if (i_status.sqrt_done) n_fsm = cglp_pkg::S_SQD_GO;
            cglp_pkg::S_SQD_GO:   n_fsm = cglp_pkg::S_SQD_WAIT;
            cglp_pkg::S_SQD_WAIT: if (i_status.sqrt_done) n_fsm = cglp_pkg::S_DIV_GO;
            cglp_pkg::S_DIV_GO:   n_fsm = cglp_pkg::S_DIV_WAIT;
            cglp_pkg::S_DIV_WAIT: if (i_status.div_done) n_fsm = cglp_pkg::S_CM_GO;
            cglp_pkg::S_CM_GO:    n_fsm = cglp_pkg::S_CM_WAIT;
            cglp_pkg::S_CM_WAIT:  if (i_status.mul_done) n_fsm = cglp_pkg::S_RES;
            cglp_pkg::S_RES: begin
                n_comp = 1'b1;
                n_fsm  = r_comp ? cglp_pkg::S_DONE : cglp_pkg::S_DIV_GO;
            end
            cglp_pkg::S_DONE:     if (i_out_free) n_fsm = cglp_pkg::S_IDLE;
            default:              n_fsm = cglp_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.comp = r_comp;
        unique case (r_fsm)
            cglp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cglp_pkg::S_CHK:      o_cmd.set_stuck = i_status.stuck;
            cglp_pkg::S_LCG1:     o_cmd.lcg1 = 1'b1;
            cglp_pkg::S_LCG2:     o_cmd.lcg2 = 1'b1;
            cglp_pkg::S_SQ1_GO: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_SQ1;
            end
            cglp_pkg::S_SQ1_CAP: begin
                o_cmd.cap_sq1 = 1'b1;
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_SQ2;
            end
            cglp_pkg::S_SQ2_CAP:  o_cmd.cap_sq2 = 1'b1;
            cglp_pkg::S_TEST: begin
                o_cmd.commit     = i_status.test_ok;
                o_cmd.norm_start = i_status.test_ok;
            end
            cglp_pkg::S_NORM:     o_cmd.norm_step = 1'b1;
            cglp_pkg::S_MCAP: begin
                o_cmd.cap_m   = 1'b1;
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_LOG;
            end
            cglp_pkg::S_LOG_GO: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_LOG;
            end
            cglp_pkg::S_LOG_UPD:  o_cmd.log_upd = 1'b1;
            cglp_pkg::S_LN_GO: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_LN;
            end
            cglp_pkg::S_SQR_GO: begin
                o_cmd.sqrt_go  = 1'b1;
                o_cmd.sqrt_sel = cglp_pkg::SQRT_LN;
            end
            cglp_pkg::S_SQD_GO: begin
                o_cmd.cap_r    = 1'b1;
                o_cmd.sqrt_go  = 1'b1;
                o_cmd.sqrt_sel = cglp_pkg::SQRT_DEN;
            end
            cglp_pkg::S_DIV_GO:   o_cmd.div_go = 1'b1;
            cglp_pkg::S_CM_GO: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = cglp_pkg::MUL_COMP;
            end
            cglp_pkg::S_RES:      o_cmd.res_cap = 1'b1;
            cglp_pkg::S_DONE:     o_cmd.out_load = i_out_free;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/cglp_datapath.sv @@
// ----------------------------------------------------------------------------
// cglp_datapath
// generator state, shared 32x32 multiply unit, root and divide units
// ----------------------------------------------------------------------------
`default_nettype none

module cglp_datapath #(
    parameter int OUT_FRAC_BITS = 26
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cglp_pkg::t_cmd    i_cmd,
    input  wire logic              i_reseed,
    input  wire logic [30:0]       i_seed,
    output cglp_pkg::t_status      o_status,
    output logic [31:0]            o_real,
    output logic [31:0]            o_imag,
    output logic                   o_stuck
);

    localparam int RND_SH = 63 - OUT_FRAC_BITS;

    // generator and draw
    logic [30:0]  r_state, r_s;
    logic [31:0]  r_mag1, r_mag2;
    logic         r_neg1, r_neg2;
    logic [63:0]  r_big, r_mq, r_m;
    logic [5:0]   r_cnt;
    logic [4:0]   r_j;
    logic [39:0]  r_f;
    // multiply unit
    logic [63:0]  r_mx, r_my, r_p;
    logic [2:0]   r_mk;
    logic [1:0]   r_psh;
    logic         r_pv, r_mbusy;
    logic [127:0] r_acc;
    // root unit
    logic [71:0]  r_rad;
    logic [37:0]  r_rem;
    logic [35:0]  r_root, r_r;
    logic [5:0]   r_sk;
    logic         r_sbusy;
    // divide unit
    logic [32:0]  r_dlo, r_q;
    logic [33:0]  r_drem;
    logic [5:0]   r_dk;
    logic         r_dbusy;
    // results
    logic [31:0]  r_real, r_imag;
    logic         r_stuck;

    logic [45:0]  w_prod;
    logic [31:0]  w_fold, w_a2, w_mag;
    logic [30:0]  w_next, w_base;
    logic         w_neg;
    logic [5:0]   w_jm;
    logic [4:0]   w_j;
    logic [63:0]  w_sq, w_x, w_y;
    logic [31:0]  w_xp, w_yp;
    logic [127:0] w_padd;
    logic [39:0]  w_st, w_trial;
    logic         w_sge;
    logic [33:0]  w_dt;
    logic         w_dge;
    logic [31:0]  w_u;
    logic [79:0]  w_rnd;
    logic [63:0]  w_res, w_sat;
    logic [31:0]  w_val;
    logic         w_cneg;

    // park-miller step, fold modulo 2^31-1
    assign w_prod = 46'(r_s) * 46'(cglp_pkg::LCG_MUL);
    assign w_fold = {1'b0, w_prod[30:0]} + {17'b0, w_prod[45:31]};
    assign w_next = (w_fold >= {1'b0, cglp_pkg::LCG_MOD})
                  ? 31'(w_fold - {1'b0, cglp_pkg::LCG_MOD}) : w_fold[30:0];
    assign w_a2   = {w_next, 1'b0};
    assign w_neg  = ~w_next[30];
    assign w_mag  = w_neg ? (32'h8000_0000 - w_a2) : (w_a2 - 32'h8000_0000);
    assign w_base = i_reseed ? i_seed : r_state;

    assign w_jm = r_cnt - 6'd1;
    assign w_j  = (r_cnt <= 6'd2) ? 5'd0 : w_jm[5:1];
    assign w_sq = r_acc[125:62];

    // multiply operand select
    always_comb begin
        case (i_cmd.mul_sel)
            cglp_pkg::MUL_SQ1: begin
                w_x = {32'b0, r_mag1};
                w_y = {32'b0, r_mag1};
            end
            cglp_pkg::MUL_SQ2: begin
                w_x = {32'b0, r_mag2};
                w_y = {32'b0, r_mag2};
            end
            cglp_pkg::MUL_LOG: begin
                w_x = r_mq;
                w_y = r_mq;
            end
            cglp_pkg::MUL_LN: begin
                w_x = {18'b0, r_cnt, 40'b0} - {24'b0, r_f};
                w_y = cglp_pkg::LN2_Q64;
            end
            default: begin
                w_x = {31'b0, r_q};
                w_y = {28'b0, r_r};
            end
        endcase
    end

    assign w_xp = (r_mk == 3'd2 || r_mk == 3'd3) ? r_mx[63:32] : r_mx[31:0];
    assign w_yp = (r_mk == 3'd1 || r_mk == 3'd3) ? r_my[63:32] : r_my[31:0];

    always_comb begin
        case (r_psh)
            2'd0:    w_padd = {64'b0, r_p};
            2'd1:    w_padd = {32'b0, r_p, 32'b0};
            default: w_padd = {r_p, 64'b0};
        endcase
    end

    // root step
    assign w_st    = {r_rem, r_rad[71:70]};
    assign w_trial = {2'b0, r_root, 2'b01};
    assign w_sge   = (w_st >= w_trial);

    // divide step, divisor is the finished root
    assign w_u   = (i_cmd.comp ? r_mag2 : r_mag1) << r_j;
    assign w_dt  = {r_drem[32:0], r_dlo[32]};
    assign w_dge = (w_dt >= {1'b0, r_root[32:0]});

    // round half up, apply sign, saturate
    assign w_rnd  = r_acc[79:0] + (80'd1 << (RND_SH - 1));
    assign w_res  = 64'(w_rnd >> RND_SH);
    assign w_cneg = i_cmd.comp ? r_neg2 : r_neg1;
    always_comb begin
        if (w_cneg) begin
            w_sat = (w_res > 64'h8000_0000) ? 64'h8000_0000 : w_res;
            w_val = 32'(64'd0 - w_sat);
        end else begin
            w_sat = (w_res > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : w_res;
            w_val = w_sat[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 31'd1;
            r_mbusy <= 1'b0;
            r_pv    <= 1'b0;
            r_sbusy <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_s <= w_base ^ cglp_pkg::XOR_MASK;
                if (i_reseed) r_state <= i_seed;
            end
            if (i_cmd.lcg1 || i_cmd.lcg2) r_s <= w_next;
            if (i_cmd.lcg1) begin
                r_mag1 <= w_mag;
                r_neg1 <= w_neg;
            end
            if (i_cmd.lcg2) begin
                r_mag2 <= w_mag;
                r_neg2 <= w_neg;
            end
            if (i_cmd.cap_sq1) r_big <= r_acc[63:0];
            if (i_cmd.cap_sq2) r_big <= r_big + r_acc[63:0];
            if (i_cmd.commit)  r_state <= r_s;

            // normalize to q2.62
            if (i_cmd.norm_start) begin
                r_mq  <= r_big;
                r_cnt <= '0;
            end else if (i_cmd.norm_step) begin
                if (r_mq[62:55] == 8'd0) begin
                    r_mq  <= r_mq << 8;
                    r_cnt <= r_cnt + 6'd8;
                end else if (!r_mq[62]) begin
                    r_mq  <= r_mq << 1;
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            if (i_cmd.cap_m) begin
                r_m <= r_big << {w_j, 1'b0};
                r_j <= w_j;
                r_f <= '0;
            end

            // one log2 bit per squaring
            if (i_cmd.log_upd) begin
                if (w_sq[63]) begin
                    r_mq <= w_sq >> 1;
                    r_f  <= {r_f[38:0], 1'b1};
                end else begin
                    r_mq <= w_sq;
                    r_f  <= {r_f[38:0], 1'b0};
                end
            end

            // 64x64 multiply as four 32x32 partial products
            if (i_cmd.mul_go) begin
                r_mx    <= w_x;
                r_my    <= w_y;
                r_mk    <= '0;
                r_mbusy <= 1'b1;
                r_pv    <= 1'b0;
                r_acc   <= '0;
            end else if (r_mbusy) begin
                if (r_pv) r_acc <= r_acc + w_padd;
                if (r_mk != cglp_pkg::MUL_LAST) begin
                    r_p   <= 64'(w_xp) * 64'(w_yp);
                    r_psh <= (r_mk == 3'd0) ? 2'd0 : (r_mk == 3'd3) ? 2'd2 : 2'd1;
                    r_pv  <= 1'b1;
                end else begin
                    r_pv    <= 1'b0;
                    r_mbusy <= 1'b0;
                end
                r_mk <= r_mk + 3'd1;
            end

            // integer root, one digit per cycle
            if (i_cmd.cap_r) r_r <= r_root;
            if (i_cmd.sqrt_go) begin
                r_rad   <= (i_cmd.sqrt_sel == cglp_pkg::SQRT_LN) ? {r_acc[111:48], 8'b0}
                                                                 : {6'b0, r_m, 2'b0};
                r_rem   <= '0;
                r_root  <= '0;
                r_sk    <= '0;
                r_sbusy <= 1'b1;
            end else if (r_sbusy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= w_sge ? 38'(w_st - w_trial) : w_st[37:0];
                r_root <= {r_root[34:0], w_sge};
                r_sk   <= r_sk + 6'd1;
                if (r_sk == cglp_pkg::SQRT_LAST) r_sbusy <= 1'b0;
            end

            // restoring divide, one quotient bit per cycle
            if (i_cmd.div_go) begin
                r_drem  <= {3'b0, w_u[31:1]};
                r_dlo   <= {w_u[0], 32'b0};
                r_q     <= '0;
                r_dk    <= '0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                r_drem <= w_dge ? (w_dt - {1'b0, r_root[32:0]}) : w_dt;
                r_dlo  <= r_dlo << 1;
                r_q    <= {r_q[31:0], w_dge};
                r_dk   <= r_dk + 6'd1;
                if (r_dk == cglp_pkg::DIV_LAST) r_dbusy <= 1'b0;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_stuck) begin
            r_real  <= '0;
            r_imag  <= '0;
            r_stuck <= 1'b1;
        end else if (i_cmd.res_cap) begin
            if (i_cmd.comp) r_imag <= w_val;
            else            r_real <= w_val;
            r_stuck <= 1'b0;
        end
    end

    always_comb begin
        o_status.stuck     = (r_s == '0) || (r_s == cglp_pkg::LCG_MOD);
        o_status.test_ok   = (r_big != '0) && (r_big <= cglp_pkg::ACCEPT_MAX);
        o_status.norm_done = r_mq[62];
        o_status.mul_done  = r_mbusy && (r_mk == cglp_pkg::MUL_LAST);
        o_status.sqrt_done = r_sbusy && (r_sk == cglp_pkg::SQRT_LAST);
        o_status.div_done  = r_dbusy && (r_dk == cglp_pkg::DIV_LAST);
    end

    assign o_real  = r_real;
    assign o_imag  = r_imag;
    assign o_stuck = r_stuck;

endmodule

`default_nettype wire

@@ sv/complex_gaussian_lcg_polar.sv @@
// ----------------------------------------------------------------------------
// complex_gaussian_lcg_polar
// complex gaussian samples from a park-miller generator and polar rejection
// ----------------------------------------------------------------------------
// one request on the s_axis channel (tdata bit 0: reseed) gives one complex
// sample on the m_axis channel: tdata[31:0] real, tdata[63:32] imaginary,
// both signed with OUT_FRAC_BITS fraction bits; tuser[0] flags a stuck state
// the seed register sits at apb address 0 and is loaded with a request
// whose reseed bit is set; reset sets seed and generator state to 1
// each sample takes the draws up to an accepted pair, the 40 squarings of
// the log, each through the single 32x32 multiplier in four partial
// products, then two 36-step roots and two 33-step divides; a stuck state
// skips all of these and returns zeros
// one request is worked at a time; s_axis tready is high only when the
// sequencer is idle, and a finished sample waits in the output register so
// the next request is taken while m_axis is stalled; the sequencer holds a
// second finished sample until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module complex_gaussian_lcg_polar #(
    parameter int OUT_FRAC_BITS = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [0] reseed
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [31:0] real_part, [63:32] imag_part
    output logic [0:0]       o_m_axis_tuser,   // [0] stuck_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_SEED = 1'b0;

    logic [30:0]       r_seed;
    logic              r_ovalid;
    logic [63:0]       r_odata;
    logic              r_ouser;
    cglp_pkg::t_cmd    w_cmd;
    cglp_pkg::t_status w_status;
    logic [31:0]       w_real, w_imag;
    logic              w_stuck, w_out_free;

    assign pready = 1'b1;
    assign prdata = {1'b0, r_seed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 31'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEED) begin
            r_seed <= pwdata[30:0];
        end
    end

    assign w_out_free = !r_ovalid || i_m_axis_tready;

    cglp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cglp_datapath #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_reseed (i_s_axis_tdata[0]),
        .i_seed   (r_seed),
        .o_status (w_status),
        .o_real   (w_real),
        .o_imag   (w_imag),
        .o_stuck  (w_stuck)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_odata <= {w_imag, w_real};
            r_ouser <= w_stuck;
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_ouser;

endmodule

`default_nettype wire

@@ sv/cglp_checker.sv @@
// ----------------------------------------------------------------------------
// cglp_checker
// port-level checks of the complex gaussian sample generator
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cglp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [7:0]  i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // stalled result holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // stuck state returns zeros
    `CHK_IMPLY(a_stuck_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 64'd0)

    // no result in the cycle right after a request
    `CHK_NEXT(a_min_latency, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid, !o_m_axis_tvalid)

    // seed write reads back
    `CHK_NEXT(a_seed_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[2], prdata[30:0] == $past(pwdata[30:0]))

endmodule

bind complex_gaussian_lcg_polar cglp_checker u_cglp_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the complex gaussian sample generator
// ----------------------------------------------------------------------------
// a queue of reseed requests feeds a clocked stream driver; a bit-exact model
// of the park-miller draw and polar transform predicts every sample, and a
// clocked monitor compares each sample on the master stream in order. the
// seed register is rewritten over the apb port between drained phases,
// including the extreme seeds and the two seeds that lock the generator.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = 26;
    localparam int LIMIT     = 8000000;
    localparam int TAIL      = 600;
    localparam logic [2:0] ADDR_SEED  = 3'd0;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        stuck;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'd0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    wire         s_ready, m_valid, pready;
    wire  [63:0] m_data;
    wire  [0:0]  m_user;
    wire  [31:0] prdata;

    logic        pending_reseed[$];
    t_sample     sample_q[$];
    logic [30:0] seed_reg = 31'd1;
    logic [30:0] gen_state = 31'd1;
    logic        s_taken = 1'b0;
    logic        hold = 1'b1;
    logic        quiet = 1'b0;
    int          errors = 0;
    int          cycles = 0;

    complex_gaussian_lcg_polar #(.OUT_FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),   // [0] reseed
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),   // [31:0] real_part, [63:32] imag_part
        .o_m_axis_tuser(m_user),   // [0] stuck_error
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] root_ext(logic [63:0] x, int extra);
        logic [63:0] root, rem, pair, trial;
        root = 0;
        rem = 0;
        for (int i = 31 + extra; i >= 0; i--) begin
            pair = (i >= extra) ? ((x >> (2 * (i - extra))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] scale_part(longint a, int j, logic [63:0] d,
                                               logic [63:0] r);
        logic [63:0]  mag, c, res;
        logic [127:0] prod;
        int           sh;
        sh = 63 - FRAC;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        c = ((mag << j) << 32) / d;
        prod = 128'(c) * 128'(r) + (128'd1 << (sh - 1));
        res = 64'(prod >> sh);
        if (a < 0) begin
            if (res > 64'h8000_0000) res = 64'h8000_0000;
            return 32'(64'd0 - res);
        end
        if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
        return res[31:0];
    endfunction

    function automatic logic [30:0] lcg_step(logic [30:0] s);
        return 31'((64'(s) * 64'(cglp_pkg::LCG_MUL)) % 64'(cglp_pkg::LCG_MOD));
    endfunction

    function automatic t_sample gaussian_draw(logic reseed);
        t_sample      res;
        logic [30:0]  s, s1, s2;
        longint       a1, a2;
        logic [63:0]  big, mq, f, nl2, l56, r, m, d;
        logic [127:0] prod;
        int           n, j;
        if (reseed) gen_state = seed_reg;
        s = gen_state ^ cglp_pkg::XOR_MASK;
        if (s == 31'd0 || s == cglp_pkg::LCG_MOD) begin
            res.re = 0;
            res.im = 0;
            res.stuck = 1'b1;
            return res;
        end
        forever begin
            s1 = lcg_step(s);
            s2 = lcg_step(s1);
            s = s2;
            a1 = 2 * longint'(s1) - 64'sd2147483648;
            a2 = 2 * longint'(s2) - 64'sd2147483648;
            big = 64'(a1 * a1) + 64'(a2 * a2);
            if (big != 0 && big <= cglp_pkg::ACCEPT_MAX) break;
        end
        gen_state = s;
        n = 0;
        while (n < 62 && (big >> (n + 1)) != 0) n++;
        mq = big << (62 - n);
        f = 0;
        for (int i = 0; i < 40; i++) begin
            prod = 128'(mq) * 128'(mq);
            mq = prod[125:62];
            f = f << 1;
            if (mq[63]) begin
                mq = mq >> 1;
                f = f | 64'd1;
            end
        end
        nl2 = (64'(62 - n) << 40) - f;
        prod = 128'(nl2) * 128'(cglp_pkg::LN2_Q64);
        l56 = prod[111:48];
        r = root_ext(l56, 4);
        m = big;
        j = 0;
        while (m < (64'd1 << 60)) begin
            m = m << 2;
            j++;
        end
        d = root_ext(m, 1);
        res.re = scale_part(a1, j, d, r);
        res.im = scale_part(a2, j, d, r);
        res.stuck = 1'b0;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // request accept and prediction
    always @(posedge i_clk) begin
        s_taken = s_valid && s_ready;
        if (s_taken) sample_q.push_back(gaussian_draw(s_data[0]));
    end

    // sample monitor
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                report("unexpected sample", m_data[31:0], 32'd0);
            end else begin
                want = sample_q.pop_front();
                if (m_data[31:0] !== want.re) report("real", m_data[31:0], want.re);
                if (m_data[63:32] !== want.im) report("imag", m_data[63:32], want.im);
                if (m_user[0] !== want.stuck)
                    report("stuck", 32'(m_user), 32'(want.stuck));
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        logic       v;
        logic [7:0] d;
        v = s_valid;
        d = s_data;
        if (!s_valid || s_taken) begin
            if (pending_reseed.size() > 0 && !hold && (quiet || $urandom_range(99) >= 27)) begin
                v = 1'b1;
                d = {7'd0, pending_reseed.pop_front()};
            end else begin
                v = 1'b0;
            end
        end
        s_valid <= v;
        s_data <= d;
        m_ready <= quiet || ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_SEED) seed_reg = value[30:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        hold = 1'b0;
        wait (pending_reseed.size() == 0 && !s_valid && sample_q.size() == 0);
        hold = 1'b1;
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic seeded_run(logic [31:0] seed, int count, int reseed_pct);
        apb_write(ADDR_SEED, seed);
        pending_reseed.push_back(1'b1);
        for (int i = 1; i < count; i++)
            pending_reseed.push_back($urandom_range(99) < reseed_pct);
        drain();
    endtask

    initial begin
        logic [31:0] seed;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset seed without a register write
        pending_reseed.push_back(1'b0);
        pending_reseed.push_back(1'b0);
        pending_reseed.push_back(1'b1);
        pending_reseed.push_back(1'b0);
        drain();
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        pending_reseed.push_back(1'b1);
        drain();
        seeded_run(32'h7FFF_FFFF, 3, 0);
        seeded_run(32'h0000_0000, 3, 0);
        seeded_run(32'hFFFF_FFFE, 2, 0);
        // locked generator: masked state of zero, then of the modulus
        seeded_run({1'b0, cglp_pkg::XOR_MASK}, 3, 0);
        seeded_run({1'b0, cglp_pkg::XOR_MASK ^ cglp_pkg::LCG_MOD}, 3, 0);
        seeded_run(32'd1, 3, 50);
        seeded_run(32'd2147483646, 3, 0);

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(5))
                0: seed = 32'd1;
                1: seed = 32'd2147483646;
                default: seed = $urandom;
            endcase
            quiet = (p == 3);
            seeded_run(seed, 210, 8);
        end
        quiet = 1'b0;

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
